// ----- hw/rtl/iiel_pkg.sv -----
package iiel_pkg;

    localparam int DEPTH   = 32;
    localparam int ITEM_W  = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 5;
    localparam int CNT_OUT_W = 6;
    localparam int VALUE_W  = 32;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ERASE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_ERASE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t        mode;
        logic [IDX_W-1:0]  pos;
        logic [ITEM_W-1:0] item;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/iiel_cell.sv -----
module iiel_cell (
    input  logic                        clk,
    input  logic [iiel_pkg::IDX_W-1:0]  idx,
    input  iiel_pkg::cell_cmd_t         cmd,
    input  logic [iiel_pkg::ITEM_W-1:0] prev_entry,
    input  logic [iiel_pkg::ITEM_W-1:0] next_entry,
    output logic [iiel_pkg::ITEM_W-1:0] entry,
    output logic                        match
);

    logic [iiel_pkg::ITEM_W-1:0] entry_reg;
    logic [iiel_pkg::ITEM_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.mode)
            iiel_pkg::CM_INSERT:
            begin
                if (idx == cmd.pos)
                begin
                    entry_next = cmd.item;
                end
                else if (idx > cmd.pos)
                begin
                    entry_next = prev_entry;
                end
            end
            iiel_pkg::CM_ERASE:
            begin
                if (idx >= cmd.pos)
                begin
                    entry_next = next_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg == cmd.item);

endmodule

// ----- hw/rtl/iiel_find.sv -----
module iiel_find (
    input  logic [iiel_pkg::DEPTH-1:0]   match,
    input  logic [iiel_pkg::COUNT_W-1:0] count,
    output logic                         hit,
    output logic [iiel_pkg::IDX_W-1:0]   pos
);

    always_comb
    begin
        hit = 1'b0;
        pos = '0;
        for (int i = iiel_pkg::DEPTH - 1; i >= 0; i--)
        begin
            if (match[i] && (iiel_pkg::COUNT_W'(i) < count))
            begin
                hit = 1'b1;
                pos = iiel_pkg::IDX_W'(i);
            end
        end
    end

endmodule

// ----- hw/rtl/indexed_insert_erase_list_unit.sv -----
// an accepted input transaction passes the input registers, the execute step registers and the output register
// no new transaction is accepted until the result of the last one is loaded into the output register
// the cell chain shifts the entries from the given position onward and compares every entry in the execute step
// a result waiting on the output holds the next result in the done step and stalls input
// reset (rst_n low, asynchronous) empties the list and clears the handshake state
module indexed_insert_erase_list_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // func [2:0], position [8:3], item_value [40:9], zero fill
    input  logic [iiel_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status [1:0], removed_item [33:2], found_position [38:34],
    // entry_count [44:39], is_empty [45], zero fill
    output logic [iiel_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    iiel_pkg::state_t state_reg;
    iiel_pkg::state_t state_next;

    logic [iiel_pkg::FUNC_W-1:0]   func_reg;
    logic [iiel_pkg::POS_W-1:0]    pos_reg;
    logic [iiel_pkg::ITEM_W-1:0]   item_reg;
    logic [iiel_pkg::COUNT_W-1:0]  count_reg;
    logic [iiel_pkg::COUNT_W-1:0]  count_next;
    logic [iiel_pkg::STATUS_W-1:0] status_reg;
    logic [iiel_pkg::STATUS_W-1:0] status_next;
    logic [iiel_pkg::ITEM_W-1:0]   removed_reg;
    logic [iiel_pkg::ITEM_W-1:0]   removed_next;
    logic [iiel_pkg::DEPTH-1:0]    match_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [iiel_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [iiel_pkg::OUT_DATA_W-1:0] out_data_next;

    iiel_pkg::cell_cmd_t           cmd;
    logic [iiel_pkg::ITEM_W-1:0]   entry_vec [iiel_pkg::DEPTH];
    logic [iiel_pkg::DEPTH-1:0]    match_vec;
    logic                          find_hit;
    logic [iiel_pkg::IDX_W-1:0]    find_pos;
    logic [iiel_pkg::IDX_W-1:0]    last_idx;
    logic                          accept;
    logic                          list_full;
    logic [iiel_pkg::STATUS_W-1:0] fin_status;
    logic [iiel_pkg::IDX_W-1:0]    fin_found;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign list_full = (count_reg == iiel_pkg::COUNT_W'(iiel_pkg::DEPTH));
    assign last_idx  = iiel_pkg::IDX_W'(count_reg - iiel_pkg::COUNT_W'(1));

    genvar g;
    generate
        for (g = 0; g < iiel_pkg::DEPTH; g++)
        begin : g_cell
            logic [iiel_pkg::ITEM_W-1:0] prev_w;
            logic [iiel_pkg::ITEM_W-1:0] next_w;
            if (g == 0)
            begin : g_first
                assign prev_w = '0;
            end
            else
            begin : g_mid_prev
                assign prev_w = entry_vec[g-1];
            end
            if (g == iiel_pkg::DEPTH - 1)
            begin : g_last
                assign next_w = '0;
            end
            else
            begin : g_mid_next
                assign next_w = entry_vec[g+1];
            end
            iiel_cell u_cell (
                .clk        (clk),
                .idx        (iiel_pkg::IDX_W'(g)),
                .cmd        (cmd),
                .prev_entry (prev_w),
                .next_entry (next_w),
                .entry      (entry_vec[g]),
                .match      (match_vec[g])
            );
        end
    endgenerate

    iiel_find u_find (
        .match (match_reg),
        .count (count_reg),
        .hit   (find_hit),
        .pos   (find_pos)
    );

    // execute step: status, removed entry, next entry count and cell command
    always_comb
    begin
        cmd.mode     = iiel_pkg::CM_HOLD;
        cmd.pos      = '0;
        cmd.item     = item_reg;
        status_next  = iiel_pkg::STATUS_OK;
        removed_next = '0;
        count_next   = count_reg;
        unique case (func_reg)
            iiel_pkg::FUNC_INSERT:
            begin
                if (pos_reg > count_reg)
                begin
                    status_next = iiel_pkg::STATUS_RANGE;
                end
                else if (list_full)
                begin
                    status_next = iiel_pkg::STATUS_FULL;
                end
                else
                begin
                    cmd.mode   = iiel_pkg::CM_INSERT;
                    cmd.pos    = pos_reg[iiel_pkg::IDX_W-1:0];
                    count_next = count_reg + iiel_pkg::COUNT_W'(1);
                end
            end
            iiel_pkg::FUNC_ERASE:
            begin
                if (pos_reg >= count_reg)
                begin
                    status_next = iiel_pkg::STATUS_RANGE;
                end
                else
                begin
                    cmd.mode     = iiel_pkg::CM_ERASE;
                    cmd.pos      = pos_reg[iiel_pkg::IDX_W-1:0];
                    removed_next = entry_vec[pos_reg[iiel_pkg::IDX_W-1:0]];
                    count_next   = count_reg - iiel_pkg::COUNT_W'(1);
                end
            end
            iiel_pkg::FUNC_PUSH:
            begin
                if (list_full)
                begin
                    status_next = iiel_pkg::STATUS_FULL;
                end
                else
                begin
                    cmd.mode   = iiel_pkg::CM_INSERT;
                    cmd.pos    = count_reg[iiel_pkg::IDX_W-1:0];
                    count_next = count_reg + iiel_pkg::COUNT_W'(1);
                end
            end
            iiel_pkg::FUNC_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = iiel_pkg::STATUS_RANGE;
                end
                else
                begin
                    cmd.mode     = iiel_pkg::CM_ERASE;
                    cmd.pos      = last_idx;
                    removed_next = entry_vec[last_idx];
                    count_next   = count_reg - iiel_pkg::COUNT_W'(1);
                end
            end
            default:
            begin
                status_next = iiel_pkg::STATUS_OK;
            end
        endcase
        if (state_reg != iiel_pkg::ST_EXEC)
        begin
            cmd.mode   = iiel_pkg::CM_HOLD;
            count_next = count_reg;
        end
    end

    // control and output register
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        s_axis_tready  = (state_reg == iiel_pkg::ST_IDLE);
        fin_status     = status_reg;
        fin_found      = '0;
        if (func_reg == iiel_pkg::FUNC_FIND)
        begin
            fin_status = find_hit ? iiel_pkg::STATUS_OK : iiel_pkg::STATUS_NOT_FOUND;
            fin_found  = find_hit ? find_pos : '0;
        end
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            iiel_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = iiel_pkg::ST_EXEC;
                end
            end
            iiel_pkg::ST_EXEC:
            begin
                state_next = iiel_pkg::ST_DONE;
            end
            iiel_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {
                        2'b00,
                        (count_reg == '0),
                        iiel_pkg::CNT_OUT_W'(count_reg),
                        iiel_pkg::FOUND_W'(fin_found),
                        iiel_pkg::VALUE_W'(removed_reg),
                        fin_status
                    };
                    state_next     = iiel_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iiel_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iiel_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            func_reg <= s_axis_tdata[2:0];
            pos_reg  <= s_axis_tdata[8:3];
            item_reg <= iiel_pkg::ITEM_W'(s_axis_tdata[40:9]);
        end
        if (state_reg == iiel_pkg::ST_EXEC)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            match_reg   <= match_vec;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
